FILE: hdl/gf2n_polynomial_hash_macros.svh
// Assertion macros for the GF(2^n) polynomial hash.
// No dependencies; included by the top level only.
`ifndef GF2N_POLYNOMIAL_HASH_MACROS_SVH
`define GF2N_POLYNOMIAL_HASH_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GPH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gf2n_polynomial_hash: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define GPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gf2n_polynomial_hash: next-cycle check failed");

`endif

FILE: hdl/gf2nph_pkg.sv
// Shared types and constants for the GF(2^n) polynomial hash.
// No dependencies; used by gf2nph_clmul, gf2n_polynomial_hash, gf2nph_checker and the testbench.
`timescale 1ns / 1ps

package gf2nph_pkg;

    // field size in 64-bit words
    localparam int WORDS   = 2;
    localparam int WORD_W  = 64;
    localparam int HALF_W  = WORD_W / 2;
    localparam int PART_W  = WORD_W + HALF_W - 1;
    localparam int FIELD_W = WORDS * WORD_W;
    localparam int PROD_W  = 2 * FIELD_W;
    localparam int WIDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int POS_W   = $clog2(4 * WORDS);
    localparam int OUT_W   = $clog2(WORDS + 1);
    localparam int TAP_W   = 6;
    localparam int TCNT_W  = 2;
    localparam int CIDX_W  = 3;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_POINT0    = 3'd0;
    localparam logic [CIDX_W-1:0] REG_POINT1    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_POINT2    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_POINT3    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_TAP_COUNT = 3'd4;
    localparam logic [CIDX_W-1:0] REG_TAP0      = 3'd5;
    localparam logic [CIDX_W-1:0] REG_TAP1      = 3'd6;
    localparam logic [CIDX_W-1:0] REG_TAP2      = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0] coef_word;
        logic              end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] hash_word;
        logic              last_word;
    } out_word_t;

endpackage

FILE: hdl/gf2nph_clmul.sv
// 64 x 32 carry-less multiplier, the shared arithmetic unit of the hash.
// Depends on gf2nph_pkg.
`timescale 1ns / 1ps

module gf2nph_clmul (
    input  logic [gf2nph_pkg::WORD_W-1:0] a,
    input  logic [gf2nph_pkg::HALF_W-1:0] b,
    output logic [gf2nph_pkg::PART_W-1:0] p
);

    // xor of shifted copies of a, one per set bit of b
    always_comb begin
        logic [gf2nph_pkg::PART_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < gf2nph_pkg::HALF_W; i++) begin
            if (b[i]) begin
                acc = acc ^ (gf2nph_pkg::PART_W'(a) << i);
            end
        end
        p = acc;
    end

endmodule

FILE: hdl/gf2n_polynomial_hash.sv
// Polynomial evaluation hash over GF(2^(64*WORDS)), Horner's rule.
// Channels: s_ (coefficient words in), m_ (hash words out), cfg_ (registers).
// Each coefficient is WORDS words, low word first; end_of_message on the
// final word of the final coefficient. The hash leaves as WORDS words, low
// first, last_word set on the top word.
// Order: a non-final word of a coefficient is taken while idle. The final
// word starts the update acc = acc*point + coef on one 64x32 carry-less
// multiplier: a multiply step per acc word and point half-word pair, then
// load, three fold, sum, three reduce and finish steps; s_ready is low
// throughout. Hash words appear from the cycle after the finish, one per
// cycle while m_ready is high. A stalled receiver holds the words; the next
// coefficients are still taken, and only a second message end waits in the
// finish state until the previous hash has fully gone.
// cfg_ready is always high; write only while idle. Reset (aresetn low,
// synchronous) clears the accumulator, word position and output, and returns
// the registers to their defaults.
// Depends on gf2nph_pkg, gf2nph_clmul and gf2n_polynomial_hash_macros.svh.
`timescale 1ns / 1ps
`include "gf2n_polynomial_hash_macros.svh"

module gf2n_polynomial_hash (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  gf2nph_pkg::in_word_t              s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output gf2nph_pkg::out_word_t             m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gf2nph_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [gf2nph_pkg::WORD_W-1:0]     cfg_data
);

    localparam int W  = gf2nph_pkg::WORDS;
    localparam int WW = gf2nph_pkg::WORD_W;
    localparam int FW = gf2nph_pkg::FIELD_W;
    localparam int PW = gf2nph_pkg::PROD_W;
    localparam int XW = gf2nph_pkg::WIDX_W;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_LOAD, S_FOLD, S_SUM, S_RED, S_FINISH
    } state_t;

    // configuration
    logic [FW-1:0]                     point_reg;
    logic [gf2nph_pkg::TCNT_W-1:0]     tap_count_reg;
    logic [gf2nph_pkg::TAP_W-1:0]      tap0_reg, tap1_reg, tap2_reg;

    // datapath and sequencer
    state_t                            state_reg;
    logic [XW-1:0]                     widx_reg;
    logic [XW-1:0]                     i_reg, j_reg;
    logic                              h_reg;
    logic [1:0]                        k_reg;
    logic                              eom_reg;
    logic [FW-1:0]                     acc_reg;
    logic [FW-1:0]                     coef_reg;
    logic [PW-1:0]                     prod_reg;
    logic [FW-1:0]                     m_reg;
    logic [FW-1:0]                     r_reg;
    logic [FW-1:0]                     hash_reg;
    logic [gf2nph_pkg::OUT_W-1:0]      out_left_reg;
    logic                              m_valid_reg;

    logic [WW-1:0]                     mul_a;
    logic [gf2nph_pkg::HALF_W-1:0]     mul_b;
    logic [gf2nph_pkg::PART_W-1:0]     mul_p;
    logic [gf2nph_pkg::POS_W-1:0]      pos;
    logic                              mul_last;
    logic [gf2nph_pkg::TAP_W-1:0]      tap_sel;
    logic                              tap_active;
    logic [WW-1:0]                     prod_top;
    logic [gf2nph_pkg::TAP_W:0]        fold_sh;
    logic                              k_last;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data.hash_word = hash_reg[WW-1:0];
    assign m_data.last_word = (out_left_reg == gf2nph_pkg::OUT_W'(1));

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg     <= '0;
            tap_count_reg <= 2'd3;
            tap0_reg      <= 6'd7;
            tap1_reg      <= 6'd2;
            tap2_reg      <= 6'd1;
        end else if (cfg_valid) begin
            for (int w = 0; w < W; w++) begin
                if (cfg_index == gf2nph_pkg::CIDX_W'(w)) begin
                    point_reg[w*WW +: WW] <= cfg_data;
                end
            end
            unique case (cfg_index)
                gf2nph_pkg::REG_TAP_COUNT: tap_count_reg <= cfg_data[gf2nph_pkg::TCNT_W-1:0];
                gf2nph_pkg::REG_TAP0:      tap0_reg      <= cfg_data[gf2nph_pkg::TAP_W-1:0];
                gf2nph_pkg::REG_TAP1:      tap1_reg      <= cfg_data[gf2nph_pkg::TAP_W-1:0];
                gf2nph_pkg::REG_TAP2:      tap2_reg      <= cfg_data[gf2nph_pkg::TAP_W-1:0];
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier: acc word i times point word j half h
    assign mul_a    = acc_reg[i_reg*WW +: WW];
    assign mul_b    = point_reg[(int'(j_reg) * 2 + int'(h_reg)) * gf2nph_pkg::HALF_W +:
                                gf2nph_pkg::HALF_W];
    assign pos      = (gf2nph_pkg::POS_W'(i_reg) + gf2nph_pkg::POS_W'(j_reg)) * 2'd2
                      + gf2nph_pkg::POS_W'(h_reg);
    assign mul_last = h_reg && (i_reg == XW'(W - 1)) && (j_reg == XW'(W - 1));

    gf2nph_clmul u_clmul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    // tap select for fold and reduce passes
    always_comb begin
        unique case (k_reg)
            2'd0:    tap_sel = tap0_reg;
            2'd1:    tap_sel = tap1_reg;
            default: tap_sel = tap2_reg;
        endcase
    end
    assign tap_active = ({1'b0, k_reg} < {1'b0, tap_count_reg});
    assign k_last     = (k_reg == 2'd2);
    assign prod_top   = prod_reg[PW-1 -: WW];
    assign fold_sh    = 7'd64 - {1'b0, tap_sel};

    // sequencer, datapath and output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            widx_reg     <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            h_reg        <= 1'b0;
            k_reg        <= '0;
            acc_reg      <= '0;
            out_left_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // drain hash words
            if (m_valid_reg && m_ready) begin
                hash_reg     <= hash_reg >> WW;
                out_left_reg <= out_left_reg - gf2nph_pkg::OUT_W'(1);
                if (out_left_reg == gf2nph_pkg::OUT_W'(1)) begin
                    m_valid_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        coef_reg[widx_reg*WW +: WW] <= s_data.coef_word;
                        if (widx_reg == XW'(W - 1)) begin
                            widx_reg  <= '0;
                            eom_reg   <= s_data.end_of_message;
                            prod_reg  <= '0;
                            i_reg     <= '0;
                            j_reg     <= '0;
                            h_reg     <= 1'b0;
                            state_reg <= S_MUL;
                        end else begin
                            widx_reg <= widx_reg + XW'(1);
                        end
                    end
                end
                S_MUL: begin
                    // accumulate one partial product at offset 32*pos
                    prod_reg <= prod_reg ^ (PW'(mul_p) << {pos, 5'b0});
                    h_reg    <= ~h_reg;
                    if (h_reg) begin
                        if (j_reg == XW'(W - 1)) begin
                            j_reg <= '0;
                            i_reg <= i_reg + XW'(1);
                        end else begin
                            j_reg <= j_reg + XW'(1);
                        end
                    end
                    if (mul_last) begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    m_reg     <= prod_reg[PW-1:FW];
                    k_reg     <= '0;
                    state_reg <= S_FOLD;
                end
                S_FOLD: begin
                    // bits pushed past x^n by each tap fold back into the low word
                    if (tap_active && (tap_sel != '0)) begin
                        m_reg[WW-1:0] <= m_reg[WW-1:0] ^ (prod_top >> fold_sh);
                    end
                    k_reg <= k_last ? 2'd0 : k_reg + 2'd1;
                    if (k_last) begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_reg     <= prod_reg[FW-1:0] ^ m_reg;
                    state_reg <= S_RED;
                end
                S_RED: begin
                    if (tap_active) begin
                        r_reg <= r_reg ^ (m_reg << tap_sel);
                    end
                    k_reg <= k_last ? 2'd0 : k_reg + 2'd1;
                    if (k_last) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!eom_reg) begin
                        acc_reg   <= r_reg ^ coef_reg;
                        state_reg <= S_IDLE;
                    end else if (!m_valid_reg) begin
                        hash_reg     <= r_reg ^ coef_reg;
                        out_left_reg <= gf2nph_pkg::OUT_W'(W);
                        m_valid_reg  <= 1'b1;
                        acc_reg      <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    `GPH_ASSERT_NEXT(a_acc_clears, aclk, aresetn, (state_reg == S_FINISH) && eom_reg && !m_valid_reg, (acc_reg == '0) && m_valid_reg)
    `GPH_ASSERT_NEXT(a_last_drains, aclk, aresetn, m_valid && m_ready && m_data.last_word, !m_valid)
    `GPH_ASSERT_NOW(a_widx_range, aclk, aresetn, 1'b1, widx_reg <= XW'(W - 1))
    `GPH_ASSERT_NOW(a_left_valid, aclk, aresetn, m_valid_reg, (out_left_reg != '0) && (out_left_reg <= gf2nph_pkg::OUT_W'(W)))

endmodule

FILE: tb/gf2nph_checker.sv
// Scoreboard for the GF(2^n) polynomial hash: keeps its own Horner accumulator
// and register copy, predicts each hash word and compares what leaves m_.
// Depends on gf2nph_pkg.
`timescale 1ns / 1ps

module gf2nph_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  gf2nph_pkg::in_word_t          s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  gf2nph_pkg::out_word_t         m_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [gf2nph_pkg::CIDX_W-1:0] cfg_index,
    input  logic [gf2nph_pkg::WORD_W-1:0] cfg_data,
    output int                            mismatches,
    output int                            pending,
    output int                            words_checked
);
    import gf2nph_pkg::*;

    // shadow registers and datapath state
    logic [WORD_W-1:0]  point_q [4];
    logic [TCNT_W-1:0]  tap_cnt_q;
    logic [TAP_W-1:0]   tap_q [3];
    logic [FIELD_W-1:0] acc_q;
    logic [FIELD_W-1:0] coef_q;
    int unsigned        word_pos;
    out_word_t          expected_words [$];
    out_word_t          want;

    function automatic logic [2*WORD_W-1:0] clmul64(input logic [WORD_W-1:0] a, b);
        logic [2*WORD_W-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_W; i++)
            if (b[i])
                p ^= {{WORD_W{1'b0}}, a} << i;
        return p;
    endfunction

    // acc * point, folded with the current taps exactly as the block folds
    function automatic logic [FIELD_W-1:0] times_point(input logic [FIELD_W-1:0] a);
        logic [FIELD_W-1:0]  pt;
        logic [PROD_W-1:0]   prod;
        logic [2*WORD_W-1:0] part;
        logic [WORD_W-1:0]   hi_w [WORDS];
        logic [WORD_W-1:0]   v;
        logic [FIELD_W-1:0]  res;
        int                  t;
        for (int j = 0; j < WORDS; j++)
            pt[j*WORD_W +: WORD_W] = point_q[j];
        prod = '0;
        for (int i = 0; i < WORDS; i++) begin
            for (int j = 0; j < WORDS; j++) begin
                part = clmul64(a[i*WORD_W +: WORD_W], pt[j*WORD_W +: WORD_W]);
                prod[(i+j)*WORD_W +: WORD_W] ^= part[WORD_W-1:0];
                if (i + j + 1 < 2 * WORDS)
                    prod[(i+j+1)*WORD_W +: WORD_W] ^= part[2*WORD_W-1:WORD_W];
            end
        end
        for (int j = 0; j < WORDS; j++)
            hi_w[j] = prod[(WORDS+j)*WORD_W +: WORD_W];
        // bits shifted past x^n by the top word come back into the low word
        for (int i = 0; i < tap_cnt_q; i++) begin
            t = tap_q[i];
            if (t != 0)
                hi_w[0] ^= prod[PROD_W-1 -: WORD_W] >> (WORD_W - t);
        end
        for (int j = 0; j < WORDS; j++) begin
            v = hi_w[j];
            for (int i = 0; i < tap_cnt_q; i++) begin
                t = tap_q[i];
                v ^= hi_w[j] << t;
                if (j > 0 && t != 0)
                    v ^= hi_w[j-1] >> (WORD_W - t);
            end
            res[j*WORD_W +: WORD_W] = v ^ prod[j*WORD_W +: WORD_W];
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++)
                point_q[i] = '0;
            tap_cnt_q = 2'd3;
            tap_q[0]  = 6'd7;
            tap_q[1]  = 6'd2;
            tap_q[2]  = 6'd1;
            acc_q     = '0;
            coef_q    = '0;
            word_pos  = 0;
            expected_words.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_POINT0, REG_POINT1, REG_POINT2, REG_POINT3:
                        point_q[cfg_index[1:0]] = cfg_data;
                    REG_TAP_COUNT: tap_cnt_q = cfg_data[TCNT_W-1:0];
                    REG_TAP0:      tap_q[0]  = cfg_data[TAP_W-1:0];
                    REG_TAP1:      tap_q[1]  = cfg_data[TAP_W-1:0];
                    REG_TAP2:      tap_q[2]  = cfg_data[TAP_W-1:0];
                    default: ;
                endcase
            end

            // coefficient words: Horner update on the top word of each coefficient
            if (s_valid && s_ready) begin
                coef_q[word_pos*WORD_W +: WORD_W] = s_data.coef_word;
                if (word_pos != WORDS - 1) begin
                    word_pos++;
                end else begin
                    word_pos = 0;
                    acc_q = times_point(acc_q) ^ coef_q;
                    // an end mark counts only on the last word of a coefficient
                    if (s_data.end_of_message) begin
                        for (int j = 0; j < WORDS; j++) begin
                            want.hash_word = acc_q[j*WORD_W +: WORD_W];
                            want.last_word = (j == WORDS - 1);
                            expected_words.push_back(want);
                        end
                        acc_q = '0;
                    end
                end
            end

            // hash words out
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches <= mismatches + 1;
                    $display("%0t: unexpected hash word: expected none, got %h last %b",
                             $time, m_data.hash_word, m_data.last_word);
                end else begin
                    want = expected_words.pop_front();
                    words_checked <= words_checked + 1;
                    if (m_data.hash_word !== want.hash_word
                            || m_data.last_word !== want.last_word) begin
                        mismatches <= mismatches + 1;
                        $display("%0t: hash word mismatch: expected %h last %b, got %h last %b",
                                 $time, want.hash_word, want.last_word,
                                 m_data.hash_word, m_data.last_word);
                    end
                end
            end
        end
        pending <= expected_words.size();
    end

endmodule

FILE: tb/tb_gf2n_polynomial_hash.sv
// Testbench top for gf2n_polynomial_hash: clock, reset, register settings and
// coefficient stimulus; verdict from gf2nph_checker. Depends on gf2nph_pkg.
`timescale 1ns / 1ps

module tb_gf2n_polynomial_hash;
    import gf2nph_pkg::*;

    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 52;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    in_word_t           s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    out_word_t          m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]  cfg_data  = '0;

    int mismatches;
    int pending;
    int words_checked;
    int words_sent    = 0;
    int settings_used = 1;
    bit src_idle      = 1'b1;
    bit sink_idle     = 1'b1;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    gf2n_polynomial_hash u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gf2nph_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_checked (words_checked)
    );

    // mostly random words, with zero, all ones and single bits mixed in
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [TAP_W-1:0] random_tap();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return TAP_W'($urandom_range(1, (1 << TAP_W) - 1));
        endcase
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word, input logic eom);
        int gap;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {word, eom};
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // whole coefficients; stray marks put end marks on non-final words
    task automatic send_message(input int coefs, input bit stray_marks);
        logic eom;
        for (int c = 0; c < coefs; c++) begin
            for (int w = 0; w < WORDS; w++) begin
                if (w == WORDS - 1)
                    eom = (c == coefs - 1);
                else
                    eom = stray_marks && ($urandom_range(0, 1) == 1);
                send_word(random_word(), eom);
            end
        end
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // all eight registers; unused upper bits of the tap writes carry junk
    task automatic load_setting(input logic [4*WORD_W-1:0] pt, input logic [TCNT_W-1:0] cnt,
                                input logic [TAP_W-1:0] t0, t1, t2);
        logic [WORD_W-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_POINT0, pt[0*WORD_W +: WORD_W]);
        write_reg(REG_POINT1, pt[1*WORD_W +: WORD_W]);
        write_reg(REG_POINT2, pt[2*WORD_W +: WORD_W]);
        write_reg(REG_POINT3, pt[3*WORD_W +: WORD_W]);
        write_reg(REG_TAP_COUNT, {junk[WORD_W-1:TCNT_W], cnt});
        write_reg(REG_TAP0, {junk[WORD_W-1:TAP_W], t0});
        write_reg(REG_TAP1, {junk[WORD_W-1:TAP_W], t1});
        write_reg(REG_TAP2, {junk[WORD_W-1:TAP_W], t2});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // drain hashes, then cover a coefficient that is still being multiplied
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // hash word receiver with random back-pressure
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            gap = sink_idle ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #2_000_000;
        $display("Run did not finish in time");
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [4*WORD_W-1:0] pt;
        int                  target;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers, point zero: hash equals the final coefficient
        send_word('1, 1'b0);
        send_word('1, 1'b1);
        send_word('0, 1'b1);   // end mark on a low word is ignored
        send_word({1'b1, {(WORD_W-1){1'b0}}}, 1'b1);
        settle();

        // all-ones point, highest taps
        load_setting('1, 2'd3, '1, 6'd62, 6'd61);
        send_word('1, 1'b0);
        send_word('1, 1'b0);
        send_word('0, 1'b0);
        send_word('0, 1'b0);
        send_word({(WORD_W/2){2'b01}}, 1'b1);
        send_word({(WORD_W/2){2'b10}}, 1'b1);
        send_word({{(WORD_W-1){1'b0}}, 1'b1}, 1'b0);
        send_word('0, 1'b1);
        settle();

        // no middle terms, zero taps, point one: modulo x^n + 1
        load_setting({{(4*WORD_W-1){1'b0}}, 1'b1}, 2'd0, '0, '0, '0);
        send_word('1, 1'b0);
        send_word('1, 1'b0);
        send_word({1'b1, {(WORD_W-1){1'b0}}}, 1'b0);
        send_word('1, 1'b1);
        settle();

        // single middle term at x^0, point with only its top bit set
        pt = '0;
        pt[FIELD_W-1] = 1'b1;
        load_setting(pt, 2'd1, '0, 6'd5, 6'd9);
        send_word('1, 1'b0);
        send_word('1, 1'b0);
        send_word('1, 1'b0);
        send_word('1, 1'b1);
        settle();

        // random settings and messages, idling switched per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            src_idle  = (p % 4 == 0) || (p % 4 == 2);
            sink_idle = (p % 4 == 0) || (p % 4 == 3);
            pt = {random_word(), random_word(), random_word(), random_word()};
            load_setting(pt, TCNT_W'($urandom_range(0, 3)), random_tap(), random_tap(),
                         random_tap());
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target) begin
                case ($urandom_range(0, 9))
                    0:       send_word(random_word(), 1'($urandom_range(0, 1)));
                    1:       send_message($urandom_range(1, 4), 1'b1);
                    default: send_message($urandom_range(1, 5), 1'b0);
                endcase
            end
            settle();
        end

        $display("Sent %0d coefficient words under %0d register settings,",
                 words_sent, settings_used);
        $display("checked %0d hash words with %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/gf2nph_pkg.sv
hdl/gf2nph_clmul.sv
hdl/gf2n_polynomial_hash.sv
tb/gf2nph_checker.sv
tb/tb_gf2n_polynomial_hash.sv
